// ----- sv/matrix_power_mod_word_assert.svh -----
// Assertion macros shared by the matrix power block.
`ifndef MATRIX_POWER_MOD_WORD_ASSERT_SVH
`define MATRIX_POWER_MOD_WORD_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPMW_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("matrix_power_mod_word: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MPMW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("matrix_power_mod_word: next-cycle check failed");

`endif

// ----- sv/mpmw_pkg.sv -----
// Package with shared constants and command types of the matrix power block.
package mpmw_pkg;

    localparam int FIELD_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_EXP_BITS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BR = 2'd3;

    localparam logic [FIELD_W-1:0] BASE_TL_RESET = 32'd0;
    localparam logic [FIELD_W-1:0] BASE_TR_RESET = 32'd1;
    localparam logic [FIELD_W-1:0] BASE_BL_RESET = 32'd1;
    localparam logic [FIELD_W-1:0] BASE_BR_RESET = 32'd1;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic sel_base;
        logic acc_en;
        logic shift;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_msb;
    } dp_stat_t;

endpackage

// ----- sv/matrix_power_mod_word.sv -----
// Top level of the 2x2 matrix power block, modulo a machine word.
//
//  Channel   Direction  Handshake             Contents
//  in        input      in_valid/in_ready     exponent
//  out       output     out_valid/out_ready   four entries of the result matrix
//  cfg       input      cfg_write_en          base matrix entries by cfg_index
//
// Each exponent bit takes a square step and, for a one bit, a multiply step,
// all on the one shared matrix multiply unit: eight product lanes in the
// multiply state, then the sums into the accumulator in the add state.
// Reset clears the controller and loads the base matrix {0,1,1,1}.
// A finished result waits in its output register while the next item runs;
// that item only finishes once the earlier result has been taken.
`include "matrix_power_mod_word_assert.svh"

module matrix_power_mod_word #(
    parameter int WORD_BITS = mpmw_pkg::DEF_WORD_BITS,
    parameter int EXP_BITS  = mpmw_pkg::DEF_EXP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mpmw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpmw_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mpmw_pkg::FIELD_W-1:0]   exponent,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_top_left,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_top_right,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_bottom_left,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_bottom_right
);

    mpmw_pkg::dp_cmd_t  cmd;
    mpmw_pkg::dp_stat_t stat;

    mpmw_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mpmw_datapath #(.WORD_BITS(WORD_BITS), .EXP_BITS(EXP_BITS)) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .exponent            (exponent),
        .cmd                 (cmd),
        .stat                (stat),
        .result_top_left     (result_top_left),
        .result_top_right    (result_top_right),
        .result_bottom_left  (result_bottom_left),
        .result_bottom_right (result_bottom_right)
    );

    `MPMW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `MPMW_ASSERT_NEXT(a_sum_follows_product, clk, rst_n, cmd.mul_en, cmd.acc_en)
    `MPMW_ASSERT_SAME(a_sum_after_product, clk, rst_n, cmd.acc_en, $past(cmd.mul_en))
    `MPMW_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.res_load, out_valid)

endmodule

// ----- sv/mpmw_mul_lane.sv -----
// One product lane: low word of a product, registered, split into halves when wide.
module mpmw_mul_lane #(
    parameter int WORD_BITS = mpmw_pkg::DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic [WORD_BITS-1:0] prod
);

    generate
        if (WORD_BITS <= 32) begin : g_narrow
            logic [WORD_BITS-1:0] prod_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg <= WORD_BITS'(a * b);
                end
            end

            assign prod = prod_reg;
        end
        else begin : g_wide
            localparam int HI_W = WORD_BITS - 32;
            logic [63:0]     low_reg;
            logic [HI_W-1:0] cross_a_reg;
            logic [HI_W-1:0] cross_b_reg;

            // The high half of each operand only reaches the low word through
            // the two cross products, whose low bits alone are kept.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg     <= 64'(a[31:0]) * 64'(b[31:0]);
                    cross_a_reg <= HI_W'(a[WORD_BITS-1:32] * b[31:0]);
                    cross_b_reg <= HI_W'(a[31:0] * b[WORD_BITS-1:32]);
                end
            end

            assign prod = low_reg[WORD_BITS-1:0] + {cross_a_reg + cross_b_reg, 32'b0};
        end
    endgenerate

endmodule

// ----- sv/mpmw_datapath.sv -----
// Datapath: base registers, accumulator matrix, exponent shifter and result registers.
module mpmw_datapath #(
    parameter int WORD_BITS = mpmw_pkg::DEF_WORD_BITS,
    parameter int EXP_BITS  = mpmw_pkg::DEF_EXP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mpmw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpmw_pkg::FIELD_W-1:0]   cfg_data,
    input  logic [mpmw_pkg::FIELD_W-1:0]   exponent,
    input  mpmw_pkg::dp_cmd_t              cmd,
    output mpmw_pkg::dp_stat_t             stat,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_top_left,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_top_right,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_bottom_left,
    output logic [mpmw_pkg::FIELD_W-1:0]   result_bottom_right
);

    logic [WORD_BITS-1:0] base_reg [4];
    logic [WORD_BITS-1:0] acc_reg  [4];
    logic [WORD_BITS-1:0] opnd_b   [4];
    logic [WORD_BITS-1:0] prod     [8];
    logic [EXP_BITS-1:0]  exp_reg;
    logic [mpmw_pkg::FIELD_W-1:0] res_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg[0] <= WORD_BITS'(mpmw_pkg::BASE_TL_RESET);
            base_reg[1] <= WORD_BITS'(mpmw_pkg::BASE_TR_RESET);
            base_reg[2] <= WORD_BITS'(mpmw_pkg::BASE_BL_RESET);
            base_reg[3] <= WORD_BITS'(mpmw_pkg::BASE_BR_RESET);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mpmw_pkg::REG_BASE_TL: base_reg[0] <= WORD_BITS'(cfg_data);
                mpmw_pkg::REG_BASE_TR: base_reg[1] <= WORD_BITS'(cfg_data);
                mpmw_pkg::REG_BASE_BL: base_reg[2] <= WORD_BITS'(cfg_data);
                mpmw_pkg::REG_BASE_BR: base_reg[3] <= WORD_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            opnd_b[k] = cmd.sel_base ? base_reg[k] : acc_reg[k];
        end
    end

    // Entry r of the product sums two lanes: row of r in the accumulator
    // against column of r in the second operand.
    genvar r;
    generate
        for (r = 0; r < 4; r++) begin : g_entry
            localparam int ROW = r / 2;
            localparam int COL = r % 2;

            mpmw_mul_lane #(.WORD_BITS(WORD_BITS)) u_lane0 (
                .clk  (clk),
                .en   (cmd.mul_en),
                .a    (acc_reg[2*ROW]),
                .b    (opnd_b[COL]),
                .prod (prod[2*r])
            );

            mpmw_mul_lane #(.WORD_BITS(WORD_BITS)) u_lane1 (
                .clk  (clk),
                .en   (cmd.mul_en),
                .a    (acc_reg[2*ROW+1]),
                .b    (opnd_b[2+COL]),
                .prod (prod[2*r+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg[0] <= WORD_BITS'(1);
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            acc_reg[3] <= WORD_BITS'(1);
            exp_reg    <= EXP_BITS'(exponent);
        end
        else
        begin
            if (cmd.acc_en)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    acc_reg[k] <= prod[2*k] + prod[2*k+1];
                end
            end
            if (cmd.shift)
            begin
                exp_reg <= exp_reg << 1;
            end
        end
        if (cmd.res_load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                res_reg[k] <= mpmw_pkg::FIELD_W'(acc_reg[k]);
            end
        end
    end

    assign stat.exp_msb        = exp_reg[EXP_BITS-1];
    assign result_top_left     = res_reg[0];
    assign result_top_right    = res_reg[1];
    assign result_bottom_left  = res_reg[2];
    assign result_bottom_right = res_reg[3];

endmodule

// ----- sv/mpmw_ctrl.sv -----
// Controller: sequences square and multiply steps over the exponent bits.
module mpmw_ctrl #(
    parameter int EXP_BITS = mpmw_pkg::DEF_EXP_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mpmw_pkg::dp_stat_t stat,
    output mpmw_pkg::dp_cmd_t  cmd
);

    localparam int IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQ_MUL = 3'd1;
    localparam logic [2:0] ST_SQ_ADD = 3'd2;
    localparam logic [2:0] ST_MB_MUL = 3'd3;
    localparam logic [2:0] ST_MB_ADD = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             last_bit;

    assign last_bit = (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = IDX_W'(EXP_BITS - 1);
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD:
            begin
                cmd.acc_en = 1'b1;
                if (stat.exp_msb)
                begin
                    state_next = ST_MB_MUL;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    if (last_bit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_SQ_MUL;
                    end
                end
            end
            ST_MB_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.sel_base = 1'b1;
                state_next   = ST_MB_ADD;
            end
            ST_MB_ADD:
            begin
                cmd.acc_en = 1'b1;
                cmd.shift  = 1'b1;
                if (last_bit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench that raises 2x2 base matrices to random and corner-case exponents.
module testbench;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 165;
    localparam int PHASES       = 6;

    typedef logic [mpmw_pkg::FIELD_W-1:0] word_t;

    typedef struct packed {
        word_t tl;
        word_t tr;
        word_t bl;
        word_t br;
    } mat2_t;

    typedef enum logic {
        ROW_EXPONENT,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [mpmw_pkg::CFG_IDX_W-1:0]  index;
        word_t                           value;
        bit                              known;
        mat2_t                           answer;
    } script_row_t;

    localparam mat2_t IDENTITY   = {32'd1, 32'd0, 32'd0, 32'd1};
    localparam mat2_t FIB_BASE   = {mpmw_pkg::BASE_TL_RESET, mpmw_pkg::BASE_TR_RESET,
                                    mpmw_pkg::BASE_BL_RESET, mpmw_pkg::BASE_BR_RESET};
    localparam mat2_t ALL_ONES   = {4{32'hFFFF_FFFF}};
    localparam mat2_t ALL_ZERO   = {4{32'h0000_0000}};

    logic                           clk;
    logic                           rst_n        = 1'b0;
    logic                           cfg_write_en = 1'b0;
    logic [mpmw_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    word_t                          cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    word_t                          exponent     = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    word_t                          result_top_left;
    word_t                          result_top_right;
    word_t                          result_bottom_left;
    word_t                          result_bottom_right;

    mat2_t       base_now = FIB_BASE;
    mat2_t       awaited_powers[$];
    script_row_t script[$];
    mat2_t       oldest_power;
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    matrix_power_mod_word dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .exponent            (exponent),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_top_left     (result_top_left),
        .result_top_right    (result_top_right),
        .result_bottom_left  (result_bottom_left),
        .result_bottom_right (result_bottom_right)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic mat2_t mat_product(mat2_t a, mat2_t b);
        mat2_t r;
        r.tl = a.tl * b.tl + a.tr * b.bl;
        r.tr = a.tl * b.tr + a.tr * b.br;
        r.bl = a.bl * b.tl + a.br * b.bl;
        r.br = a.bl * b.tr + a.br * b.br;
        return r;
    endfunction

    // Square-and-multiply from the top exponent bit down, all sums modulo 2^32.
    function automatic mat2_t raise_base(mat2_t b, word_t e);
        mat2_t acc;
        acc = IDENTITY;
        for (int k = mpmw_pkg::FIELD_W - 1; k >= 0; k--)
        begin
            acc = mat_product(acc, acc);
            if (e[k])
                acc = mat_product(acc, b);
        end
        return acc;
    endfunction

    function automatic void add_exponent(word_t e, bit known, mat2_t answer);
        script_row_t row;
        row.kind   = ROW_EXPONENT;
        row.index  = mpmw_pkg::REG_BASE_TL;
        row.value  = e;
        row.known  = known;
        row.answer = answer;
        script.push_back(row);
    endfunction

    function automatic void add_write(logic [mpmw_pkg::CFG_IDX_W-1:0] idx, word_t val);
        script_row_t row;
        row.kind   = ROW_WRITE;
        row.index  = idx;
        row.value  = val;
        row.known  = 1'b0;
        row.answer = ALL_ZERO;
        script.push_back(row);
    endfunction

    task automatic check_entry(string label, word_t want, word_t got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
        end
    endtask

    task automatic send_exponent(word_t e, bit known, mat2_t answer);
        mat2_t due;
        due = known ? answer : raise_base(base_now, e);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        exponent <= e;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_powers.push_back(due);
    endtask

    // Base registers change only once every outstanding item has been returned.
    task automatic write_base(logic [mpmw_pkg::CFG_IDX_W-1:0] idx, word_t val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_powers.size() != 0)
            @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            mpmw_pkg::REG_BASE_TL: base_now.tl = val;
            mpmw_pkg::REG_BASE_TR: base_now.tr = val;
            mpmw_pkg::REG_BASE_BL: base_now.bl = val;
            mpmw_pkg::REG_BASE_BR: base_now.br = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= 10);
            if (out_valid && out_ready)
            begin
                if (awaited_powers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item expected none actual %h %h %h %h", $time,
                             result_top_left, result_top_right,
                             result_bottom_left, result_bottom_right);
                end
                else
                begin
                    oldest_power = awaited_powers.pop_front();
                    check_entry("result_top_left", oldest_power.tl, result_top_left);
                    check_entry("result_top_right", oldest_power.tr, result_top_right);
                    check_entry("result_bottom_left", oldest_power.bl, result_bottom_left);
                    check_entry("result_bottom_right", oldest_power.br, result_bottom_right);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("matrix_power_mod_word verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        mat2_t phase_base [PHASES];
        word_t pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fibonacci base straight out of reset.
        add_exponent(32'd0, 1'b1, IDENTITY);
        add_exponent(32'd1, 1'b1, FIB_BASE);
        add_exponent(32'd2, 1'b1, {32'd1, 32'd1, 32'd1, 32'd2});
        add_exponent(32'd10, 1'b1, {32'd34, 32'd55, 32'd55, 32'd89});
        add_exponent(32'd47, 1'b0, ALL_ZERO);
        add_exponent(32'hFFFF_FFFF, 1'b0, ALL_ZERO);
        add_exponent(32'h8000_0000, 1'b0, ALL_ZERO);
        add_exponent(32'h5555_5555, 1'b0, ALL_ZERO);
        add_exponent(32'hAAAA_AAAA, 1'b0, ALL_ZERO);
        // Largest entries, so every product wraps.
        add_write(mpmw_pkg::REG_BASE_TL, 32'hFFFF_FFFF);
        add_write(mpmw_pkg::REG_BASE_TR, 32'hFFFF_FFFF);
        add_write(mpmw_pkg::REG_BASE_BL, 32'hFFFF_FFFF);
        add_write(mpmw_pkg::REG_BASE_BR, 32'hFFFF_FFFF);
        add_exponent(32'd0, 1'b1, IDENTITY);
        add_exponent(32'd1, 1'b1, ALL_ONES);
        add_exponent(32'd2, 1'b1, {4{32'd2}});
        add_exponent(32'hFFFF_FFFF, 1'b0, ALL_ZERO);
        add_write(mpmw_pkg::REG_BASE_TL, 32'd0);
        add_write(mpmw_pkg::REG_BASE_TR, 32'd0);
        add_write(mpmw_pkg::REG_BASE_BL, 32'd0);
        add_write(mpmw_pkg::REG_BASE_BR, 32'd0);
        add_exponent(32'd0, 1'b1, IDENTITY);
        add_exponent(32'd1, 1'b1, ALL_ZERO);
        add_exponent(32'h1234_5678, 1'b1, ALL_ZERO);
        add_write(mpmw_pkg::REG_BASE_TL, 32'd2);
        add_write(mpmw_pkg::REG_BASE_BR, 32'd3);
        add_exponent(32'd31, 1'b0, ALL_ZERO);
        add_exponent(32'd32, 1'b0, ALL_ZERO);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_base(script[i].index, script[i].value);
            else
                send_exponent(script[i].value, script[i].known, script[i].answer);
        end

        phase_base[0] = FIB_BASE;
        phase_base[1] = {$urandom, $urandom, $urandom, $urandom};
        phase_base[2] = ALL_ONES;
        phase_base[3] = {word_t'($urandom_range(0, 3)), word_t'($urandom_range(0, 3)),
                         word_t'($urandom_range(0, 3)), word_t'($urandom_range(0, 3))};
        phase_base[4] = {32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF};
        phase_base[5] = {$urandom, $urandom, $urandom, $urandom};

        for (int p = 0; p < PHASES; p++)
        begin
            write_base(mpmw_pkg::REG_BASE_TL, phase_base[p].tl);
            write_base(mpmw_pkg::REG_BASE_TR, phase_base[p].tr);
            write_base(mpmw_pkg::REG_BASE_BL, phase_base[p].bl);
            write_base(mpmw_pkg::REG_BASE_BR, phase_base[p].br);
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: pick = $urandom;
                    5, 6, 7:       pick = $urandom_range(0, 100);
                    8:             pick = 32'd1 << $urandom_range(0, 31);
                    default:       pick = ~(32'd1 << $urandom_range(0, 31));
                endcase
                send_exponent(pick, 1'b0, ALL_ZERO);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_powers.size() == 0)
            $display("matrix_power_mod_word verification clean");
        else
            $display("matrix_power_mod_word verification failed");
        $finish;
    end

endmodule
